[rtl/spsh_pkg.sv]
// Shared types and constants for the sphere pixel shader.
// Used by every module of the block; depends on nothing.
`default_nettype none

package spsh_pkg;

   localparam int RAD_W      = 24;
   localparam int ROOT_W     = 12;
   localparam int ROOT_STEPS = ROOT_W;

   localparam logic [17:0] RECIP5       = 18'd209716;
   localparam int          RECIP5_SHIFT = 20;

   localparam logic [1:0] REG_CENTER_X = 2'd0;
   localparam logic [1:0] REG_CENTER_Y = 2'd1;
   localparam logic [1:0] REG_RADIUS   = 2'd2;

   localparam logic [11:0] RADIUS_RESET = 12'd256;
   localparam logic [2:0]  SHADE_MAX    = 3'd5;

   localparam logic [6:0] GLYPH_SPACE = 7'h20;
   localparam logic [6:0] GLYPH_DOT   = 7'h2E;
   localparam logic [6:0] GLYPH_COLON = 7'h3A;
   localparam logic [6:0] GLYPH_DASH  = 7'h2D;
   localparam logic [6:0] GLYPH_EQUAL = 7'h3D;
   localparam logic [6:0] GLYPH_STAR  = 7'h2A;
   localparam logic [6:0] GLYPH_HASH  = 7'h23;

   typedef struct packed {
      logic              valid;
      logic              covered;
      logic [RAD_W-1:0]  radicand;
   } root_in_type;

   typedef struct packed {
      logic              valid;
      logic              covered;
      logic [ROOT_W-1:0] root;
   } root_out_type;

   function automatic logic [6:0] shade_glyph(input logic [2:0] shade);
      logic [6:0] g;
      case (shade)
         3'd0: g = GLYPH_SPACE;
         3'd1: g = GLYPH_DOT;
         3'd2: g = GLYPH_COLON;
         3'd3: g = GLYPH_DASH;
         3'd4: g = GLYPH_EQUAL;
         3'd5: g = GLYPH_STAR;
         3'd6: g = GLYPH_HASH;
         default: g = GLYPH_SPACE;
      endcase
      return g;
   endfunction

endpackage

`default_nettype wire

[rtl/spsh_coord.sv]
// Cell to Q.8 coordinate mapping, squared distance and disc test (five stages).
// Depends on spsh_pkg.
`default_nettype none

module spsh_coord #(
   parameter int SCREEN_COLS = 80,
   parameter int SCREEN_ROWS = 30
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire logic                in_valid,
   input  wire logic [6:0]          cell_col,
   input  wire logic [4:0]          cell_row,
   input  wire logic signed [12:0]  center_x,
   input  wire logic signed [12:0]  center_y,
   input  wire logic [23:0]         radius_sq,
   output spsh_pkg::root_in_type    root_in
);

   localparam int HALF_COLS = SCREEN_COLS / 2;
   localparam int HALF_ROWS = SCREEN_ROWS / 2;

   logic signed [10:0] off_x, off_y;
   logic [9:0]         mag_x, mag_y;
   logic [17:0]        nx_in, ny_in, nx_ff, ny_ff;
   logic               negx_ff, negy_ff, v1_ff;
   logic [35:0]        prod_x, prod_y;
   logic [15:0]        qx_in, qy_in, qx_ff, qy_ff;
   logic               negx2_ff, negy2_ff, v2_ff;
   logic signed [16:0] px, py, dx_in, dy_in, dx_ff, dy_ff;
   logic               v3_ff;
   logic signed [33:0] sqx_full, sqy_full;
   logic [31:0]        sqx_ff, sqy_ff;
   logic               v4_ff;
   logic [31:0]        d2;
   logic               cov_in;
   spsh_pkg::root_in_type root_in_in, root_in_ff;

   always_comb begin
      off_x = $signed({4'b0, cell_col}) - $signed(11'(HALF_COLS));
      off_y = $signed({6'b0, cell_row}) - $signed(11'(HALF_ROWS));
      mag_x = off_x[10] ? 10'(-off_x) : off_x[9:0];
      mag_y = off_y[10] ? 10'(-off_y) : off_y[9:0];
      nx_in = {1'b0, mag_x, 7'b0};
      ny_in = {mag_y, 8'b0};
   end

   assign prod_x = nx_ff * spsh_pkg::RECIP5;
   assign prod_y = ny_ff * spsh_pkg::RECIP5;
   assign qx_in  = prod_x[spsh_pkg::RECIP5_SHIFT +: 16];
   assign qy_in  = prod_y[spsh_pkg::RECIP5_SHIFT +: 16];

   always_comb begin
      px    = negx2_ff ? -$signed({1'b0, qx_ff}) : $signed({1'b0, qx_ff});
      py    = negy2_ff ? -$signed({1'b0, qy_ff}) : $signed({1'b0, qy_ff});
      dx_in = px - 17'(center_x);
      dy_in = py - 17'(center_y);
   end

   assign sqx_full = dx_ff * dx_ff;
   assign sqy_full = dy_ff * dy_ff;

   always_comb begin
      d2                  = sqx_ff + sqy_ff;
      cov_in              = d2 <= {8'b0, radius_sq};
      root_in_in.valid    = v4_ff;
      root_in_in.covered  = cov_in;
      root_in_in.radicand = radius_sq - d2[23:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff            <= 1'b0;
         v2_ff            <= 1'b0;
         v3_ff            <= 1'b0;
         v4_ff            <= 1'b0;
      end else if (advance) begin
         v1_ff            <= in_valid;
         v2_ff            <= v1_ff;
         v3_ff            <= v2_ff;
         v4_ff            <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         nx_ff               <= nx_in;
         ny_ff               <= ny_in;
         negx_ff             <= off_x[10];
         negy_ff             <= off_y[10];
         qx_ff               <= qx_in;
         qy_ff               <= qy_in;
         negx2_ff            <= negx_ff;
         negy2_ff            <= negy_ff;
         dx_ff               <= dx_in;
         dy_ff               <= dy_in;
         sqx_ff              <= sqx_full[31:0];
         sqy_ff              <= sqy_full[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_in_ff.valid <= 1'b0;
      end else if (advance) begin
         root_in_ff <= root_in_in;
      end
   end

   assign root_in = root_in_ff;

endmodule

`default_nettype wire

[rtl/spsh_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
// Depends on spsh_pkg.
`default_nettype none

module spsh_isqrt (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  spsh_pkg::root_in_type  root_in,
   output spsh_pkg::root_out_type root_out
);

   localparam int N = spsh_pkg::ROOT_STEPS;
   localparam int W = spsh_pkg::RAD_W;

   logic [W-1:0] rem_ff [N];
   logic [W-1:0] res_ff [N];
   logic         valid_ff [N];
   logic         cov_ff [N];

   for (genvar s = 0; s < N; s++) begin : g_step
      localparam logic [W-1:0] BIT = W'(1) << (2 * (N - 1 - s));
      logic [W-1:0] rem_prev, res_prev, trial, rem_in, res_in;
      logic         valid_prev, cov_prev;

      if (s == 0) begin : g_first
         assign rem_prev   = root_in.radicand;
         assign res_prev   = '0;
         assign valid_prev = root_in.valid;
         assign cov_prev   = root_in.covered;
      end else begin : g_next
         assign rem_prev   = rem_ff[s-1];
         assign res_prev   = res_ff[s-1];
         assign valid_prev = valid_ff[s-1];
         assign cov_prev   = cov_ff[s-1];
      end

      always_comb begin
         trial = res_prev + BIT;
         if (rem_prev >= trial) begin
            rem_in = rem_prev - trial;
            res_in = (res_prev >> 1) + BIT;
         end else begin
            rem_in = rem_prev;
            res_in = res_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (advance) begin
            valid_ff[s] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[s] <= rem_in;
            res_ff[s] <= res_in;
            cov_ff[s] <= cov_prev;
         end
      end
   end

   assign root_out.valid   = valid_ff[N-1];
   assign root_out.covered = cov_ff[N-1];
   assign root_out.root    = res_ff[N-1][spsh_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

[rtl/spsh_shade.sv]
// Shade level from depth over radius, glyph lookup and the output register.
// Depends on spsh_pkg.
`default_nettype none

module spsh_shade (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  spsh_pkg::root_out_type root_out,
   input  wire logic [11:0]       radius,
   output logic                   out_valid,
   output logic                   out_covered,
   output logic [2:0]             out_shade,
   output logic [6:0]             out_glyph
);

   logic [14:0] depth5;
   logic [14:0] rad_k [5];
   logic [2:0]  shade_in;
   logic [2:0]  shade_ff;
   logic [6:0]  glyph_ff;
   logic        valid_ff, cov_ff;

   always_comb begin
      depth5   = {1'b0, root_out.root, 2'b0} + {3'b0, root_out.root};
      shade_in = '0;
      for (int k = 0; k < 5; k++) begin
         rad_k[k] = 15'(radius) * 15'(k + 1);
         if (root_out.covered && radius != '0 && depth5 >= rad_k[k]) begin
            shade_in = 3'(k + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= root_out.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cov_ff   <= root_out.covered;
         shade_ff <= shade_in;
         glyph_ff <= spsh_pkg::shade_glyph(shade_in);
      end
   end

   assign out_valid   = valid_ff;
   assign out_covered = cov_ff;
   assign out_shade   = shade_ff;
   assign out_glyph   = glyph_ff;

   a_shade_max: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> shade_ff <= spsh_pkg::SHADE_MAX)
      else $error("shade level above maximum");

   a_uncovered_blank: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !cov_ff |-> shade_ff == '0 && glyph_ff == spsh_pkg::GLYPH_SPACE)
      else $error("uncovered word not blank");

   a_glyph_match: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> glyph_ff == spsh_pkg::shade_glyph(shade_ff))
      else $error("glyph does not match shade");

endmodule

`default_nettype wire

[rtl/sphere_pixel_shader.sv]
// Sphere pixel shader: one word per cycle; an accepted request word passes
// through 5 mapping/distance stages, 12 square-root stages and 1 shade stage
// to its response word. The whole pipeline holds when the response waits.
// Synchronous reset clears the valid bits and sets center 0, radius 256.
// Depends on spsh_pkg, spsh_coord, spsh_isqrt, spsh_shade.
`default_nettype none

module sphere_pixel_shader #(
   parameter int SCREEN_COLS = 80,
   parameter int SCREEN_ROWS = 30
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // cell_col[6:0], cell_row[11:7], zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // shade_level[2:0], glyph[9:3], zero
   output logic [0:0]       rsp_tuser,   // covered[0]
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [12:0] center_x_ff, center_y_ff;
   logic [11:0] radius_ff;
   logic [23:0] r2_ff;
   logic        csr_write;
   logic        advance;
   logic        out_valid, out_covered;
   logic [2:0]  out_shade;
   logic [6:0]  out_glyph;
   spsh_pkg::root_in_type  root_in;
   spsh_pkg::root_out_type root_out;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         radius_ff   <= spsh_pkg::RADIUS_RESET;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            spsh_pkg::REG_CENTER_X: center_x_ff <= csr_pwdata[12:0];
            spsh_pkg::REG_CENTER_Y: center_y_ff <= csr_pwdata[12:0];
            spsh_pkg::REG_RADIUS:   radius_ff   <= csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         spsh_pkg::REG_CENTER_X: csr_prdata = {19'b0, center_x_ff};
         spsh_pkg::REG_CENTER_Y: csr_prdata = {19'b0, center_y_ff};
         spsh_pkg::REG_RADIUS:   csr_prdata = {20'b0, radius_ff};
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      r2_ff <= {12'b0, radius_ff} * {12'b0, radius_ff};
   end

   assign advance    = !out_valid || rsp_tready;
   assign req_tready = advance;

   spsh_coord #(
      .SCREEN_COLS(SCREEN_COLS),
      .SCREEN_ROWS(SCREEN_ROWS)
   ) u_coord (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_tvalid),
      .cell_col (req_tdata[6:0]),
      .cell_row (req_tdata[11:7]),
      .center_x (center_x_ff),
      .center_y (center_y_ff),
      .radius_sq(r2_ff),
      .root_in  (root_in)
   );

   spsh_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .root_in (root_in),
      .root_out(root_out)
   );

   spsh_shade u_shade (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .root_out   (root_out),
      .radius     (radius_ff),
      .out_valid  (out_valid),
      .out_covered(out_covered),
      .out_shade  (out_shade),
      .out_glyph  (out_glyph)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = {6'b0, out_glyph, out_shade};
   assign rsp_tuser  = out_covered;

   a_r2_track: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> r2_ff == ({12'b0, $past(radius_ff)} * {12'b0, $past(radius_ff)}))
      else $error("radius square out of step");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> root_out == $past(root_out) && root_in == $past(root_in))
      else $error("pipeline moved during stall");

   a_no_take_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while response waits");

endmodule

`default_nettype wire

[bench/spsh_checker.sv]
// Checker for the sphere pixel shader: follows register writes on the csr port,
// predicts each response word from its request word and compares them in order.
// Depends on spsh_pkg for register indexes and glyph codes.
`default_nettype none

module spsh_checker #(
   parameter int SCREEN_COLS = 80,
   parameter int SCREEN_ROWS = 30
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [15:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [15:0] rsp_tdata,
   input  wire logic [0:0]  rsp_tuser,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic        csr_pready,
   output int               mismatches,
   output int               outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic       covered;
      logic [2:0] level;
      logic [6:0] glyph;
   } cell_shade_type;

   localparam logic [5:0][6:0] GLYPH_RAMP = {spsh_pkg::GLYPH_STAR, spsh_pkg::GLYPH_EQUAL,
                                             spsh_pkg::GLYPH_DASH, spsh_pkg::GLYPH_COLON,
                                             spsh_pkg::GLYPH_DOT, spsh_pkg::GLYPH_SPACE};
   localparam int PRINT_LIMIT = 60;

   logic [12:0] center_x_q = '0;
   logic [12:0] center_y_q = '0;
   logic [11:0] radius_q   = spsh_pkg::RADIUS_RESET;
   cell_shade_type shade_fifo[$];

   function automatic longint unsigned floor_sqrt(input longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 12; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   function automatic cell_shade_type shade_cell(input logic [6:0] col,
                                                 input logic [4:0] row);
      longint          c, rw, cx, cy, px, py, dx, dy;
      longint unsigned d2, r, r2, dz, level;
      cell_shade_type  s;
      c  = col;
      rw = row;
      cx = $signed(center_x_q);
      cy = $signed(center_y_q);
      px = ((c - SCREEN_COLS / 2) * 256) / 10;
      py = ((rw - SCREEN_ROWS / 2) * 256) / 5;
      dx = px - cx;
      dy = py - cy;
      d2 = dx * dx + dy * dy;
      r  = radius_q;
      r2 = r * r;
      s.covered = 1'b0;
      s.level   = 3'd0;
      s.glyph   = spsh_pkg::GLYPH_SPACE;
      if (d2 <= r2) begin
         dz    = floor_sqrt(r2 - d2);
         level = (r == 0) ? 0 : (5 * dz) / r;
         if (level > spsh_pkg::SHADE_MAX) level = spsh_pkg::SHADE_MAX;
         s.covered = 1'b1;
         s.level   = level[2:0];
         s.glyph   = GLYPH_RAMP[level];
      end
      return s;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) $display("spsh_checker: %0t ns: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin : watch
      cell_shade_type want;
      if (reset) begin
         center_x_q = '0;
         center_y_q = '0;
         radius_q   = spsh_pkg::RADIUS_RESET;
         shade_fifo.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               spsh_pkg::REG_CENTER_X: center_x_q = csr_pwdata[12:0];
               spsh_pkg::REG_CENTER_Y: center_y_q = csr_pwdata[12:0];
               spsh_pkg::REG_RADIUS:   radius_q   = csr_pwdata[11:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            shade_fifo.push_back(shade_cell(req_tdata[6:0], req_tdata[11:7]));
         if (rsp_tvalid && rsp_tready) begin
            if (shade_fifo.size() == 0) begin
               report_mismatch($sformatf("unexpected word: tdata %h tuser %b",
                                         rsp_tdata, rsp_tuser));
            end else begin
               want = shade_fifo.pop_front();
               if (rsp_tuser[0] !== want.covered)
                  report_mismatch($sformatf("covered %b, want %b", rsp_tuser[0],
                                            want.covered));
               if (rsp_tdata[2:0] !== want.level)
                  report_mismatch($sformatf("shade_level %0d, want %0d", rsp_tdata[2:0],
                                            want.level));
               if (rsp_tdata[9:3] !== want.glyph)
                  report_mismatch($sformatf("glyph %h, want %h", rsp_tdata[9:3],
                                            want.glyph));
            end
         end
      end
      outstanding <= shade_fifo.size();
   end

endmodule

`default_nettype wire

[bench/tb_sphere_pixel_shader.sv]
// Top of the sphere pixel shader bench: clock, reset, register setups and cell
// words with random gaps and stalls; spsh_checker does the prediction.
// Depends on spsh_pkg, sphere_pixel_shader and spsh_checker.
`default_nettype none

module tb_sphere_pixel_shader;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASES          = 14;
   localparam int CELLS_PER_PHASE = 130;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int TAIL_CYCLES     = 40;

   localparam logic [3:0] ADDR_CENTER_X = {spsh_pkg::REG_CENTER_X, 2'b00};
   localparam logic [3:0] ADDR_CENTER_Y = {spsh_pkg::REG_CENTER_Y, 2'b00};
   localparam logic [3:0] ADDR_RADIUS   = {spsh_pkg::REG_RADIUS, 2'b00};
   localparam logic [3:0] ADDR_SPARE    = 4'd12;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic [15:0] req_tdata   = '0;
   logic        rsp_tready  = 1'b0;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [15:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          mismatches;
   int          outstanding;

   int shape_cx = 0;
   int shape_cy = 0;
   int shape_r  = 256;
   bit req_quiet = 1'b0;
   bit rsp_quiet = 1'b0;
   int rsp_hold  = 0;
   int idle_cycles = 0;

   sphere_pixel_shader uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   spsh_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_pready (csr_pready),
      .mismatches (mismatches),
      .outstanding(outstanding)
   );

   always #5 clock = ~clock;

   // stall the response side for a random hold after each word
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold = 0;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if ($urandom_range(0, 39) == 0) rsp_quiet = ~rsp_quiet;
            rsp_hold = rsp_quiet ? 0 : $urandom_range(0, 14);
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_sphere_pixel_shader: FAIL");
         $finish;
      end
   end

   task automatic send_cell(input logic [6:0] col, input logic [4:0] row);
      int gap;
      if ($urandom_range(0, 39) == 0) req_quiet = ~req_quiet;
      gap = req_quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, row, col};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(input logic [3:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic apply_shape(input logic [31:0] cx, input logic [31:0] cy,
                              input logic [31:0] r);
      write_reg(ADDR_CENTER_X, cx);
      write_reg(ADDR_CENTER_Y, cy);
      write_reg(ADDR_RADIUS, r);
      write_reg(ADDR_SPARE, $urandom);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      shape_cx = $signed(cx[12:0]);
      shape_cy = $signed(cy[12:0]);
      shape_r  = r[11:0];
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      int mode, c, rw, col_span, row_span;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset shape: unit sphere at the origin; center, rim, negative
      // truncation, corners and cells beyond the screen
      send_cell(7'd40, 5'd15);
      send_cell(7'd50, 5'd15);
      send_cell(7'd30, 5'd15);
      send_cell(7'd39, 5'd15);
      send_cell(7'd41, 5'd15);
      send_cell(7'd40, 5'd14);
      send_cell(7'd40, 5'd16);
      send_cell(7'd44, 5'd17);
      send_cell(7'd0, 5'd0);
      send_cell(7'd79, 5'd29);
      send_cell(7'd80, 5'd30);
      send_cell(7'd127, 5'd31);
      drain();

      // zero radius: only the exact center is covered
      apply_shape(32'd0, 32'd0, 32'd0);
      send_cell(7'd40, 5'd15);
      send_cell(7'd41, 5'd15);
      send_cell(7'd40, 5'd16);
      drain();

      // register extremes
      apply_shape(32'd4095, -32'sd4096, 32'd4095);
      send_cell(7'd0, 5'd31);
      send_cell(7'd127, 5'd0);
      send_cell(7'd127, 5'd31);
      drain();
      apply_shape(-32'sd2048, 32'sd2048, 32'd2048);
      send_cell(7'd0, 5'd0);
      send_cell(7'd0, 5'd31);
      send_cell(7'd40, 5'd15);
      drain();

      for (int phase = 0; phase < PHASES; phase++) begin
         mode = (phase < 6) ? phase : $urandom_range(0, 5);
         case (mode)
            0: apply_shape($urandom, $urandom, $urandom);
            1: apply_shape($urandom_range(0, 4096) - 2048, $urandom_range(0, 4096) - 2048,
                           $urandom_range(1, 2048));
            2: apply_shape($urandom_range(0, 1) ? -2048 : 2048,
                           $urandom_range(0, 1) ? -2048 : 2048,
                           $urandom_range(0, 1) ? 1 : 2048);
            3: apply_shape($urandom_range(0, 2000) - 1000, $urandom_range(0, 1500) - 750,
                           $urandom_range(1, 300));
            4: begin
               if ($urandom_range(0, 1) == 0)
                  apply_shape(((int'($urandom_range(0, 79)) - 40) * 256) / 10,
                              ((int'($urandom_range(0, 29)) - 15) * 256) / 5, 0);
               else
                  apply_shape($urandom_range(0, 1) ? -4096 : 4095,
                              $urandom_range(0, 1) ? -4096 : 4095, 4095);
            end
            default: apply_shape($urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
                                 $urandom_range(2048, 4095));
         endcase
         repeat (CELLS_PER_PHASE) begin
            case ($urandom_range(0, 3))
               0: begin
                  c  = $urandom_range(0, 127);
                  rw = $urandom_range(0, 31);
               end
               1, 2: begin
                  c  = $urandom_range(0, 79);
                  rw = $urandom_range(0, 29);
               end
               default: begin
                  col_span = (shape_r * 10) / 256 + 1;
                  row_span = (shape_r * 5) / 256 + 1;
                  c  = 40 + (shape_cx * 10) / 256 +
                       int'($urandom_range(0, 2 * col_span)) - col_span;
                  rw = 15 + (shape_cy * 5) / 256 +
                       int'($urandom_range(0, 2 * row_span)) - row_span;
                  c  = (c < 0) ? 0 : ((c > 127) ? 127 : c);
                  rw = (rw < 0) ? 0 : ((rw > 31) ? 31 : rw);
               end
            endcase
            send_cell(c[6:0], rw[4:0]);
         end
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("tb_sphere_pixel_shader: PASS");
      else
         $display("tb_sphere_pixel_shader: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
